// ===== src/cpseg_pkg.sv =====
// types shared by the closest-points segment pipeline
package cpseg_pkg;

  // which path produced a result
  typedef enum logic [2:0] {
    CASE_BOTH     = 3'd0,
    CASE_FIRST    = 3'd1,
    CASE_SECOND   = 3'd2,
    CASE_GENERAL  = 3'd3,
    CASE_PARALLEL = 3'd4
  } case_t;

  localparam int unsigned DivW    = 153;
  localparam logic [16:0] OneQ16  = 17'd65536;
  localparam logic [31:0] LimInit = 32'd4295;

  // one pipeline slot; later stages fill fields that earlier ones leave alone
  typedef struct packed {
    logic [2:0][31:0]  p1;
    logic [2:0][31:0]  p2;
    logic [2:0][32:0]  d1;
    logic [2:0][32:0]  d2;
    logic [2:0][32:0]  r;
    logic [14:0][65:0] pr;
    logic [66:0]       a;
    logic [66:0]       e;
    logic [66:0]       b;
    logic [66:0]       c;
    logic [66:0]       f;
    logic              adeg;
    logic              edeg;
    case_t             code;
    logic [3:0][65:0]  phh;
    logic [3:0][67:0]  phl;
    logic [3:0][67:0]  plh;
    logic [3:0][67:0]  pll;
    logic [133:0]      pae;
    logic [133:0]      pbb;
    logic [133:0]      pbf;
    logic [133:0]      pce;
    logic [135:0]      nm;
    logic [135:0]      dn;
    logic              skip;
    logic [DivW-1:0]   rem;
    logic [DivW-1:0]   dv;
    logic [16:0]       q;
    logic [16:0]       s;
    logic [16:0]       t;
    logic [50:0]       tpl;
    logic [50:0]       tph;
    logic [85:0]       tn;
    logic [85:0]       te;
    logic              tot;
    logic [2:0][50:0]  ds1;
    logic [2:0][50:0]  ds2;
    logic [2:0][31:0]  c1;
    logic [2:0][31:0]  c2;
    logic [2:0][32:0]  df;
    logic [2:0][65:0]  sq;
    logic [63:0]       dsq;
  } item_t;

endpackage

// ===== src/closest_points_between_segments_core.sv =====
// closest points between two 3d segments, fully pipelined fixed point
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: two segments, 12 x q16.16
//  m_      | out | m_tvalid/m_tready  | m_tdata: s, t, both points, dist, case
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data: degenerate_limit
//
// one beat enters per cycle while m_ is not stalled
// the pipe holds the two 17-stage restoring dividers (one quotient bit
// per stage) plus the multiply and sum stages around them
// rst (synchronous) clears the valid bits and reloads the limit register
// a stall at m_ freezes the whole pipe; s_tready follows, nothing is dropped
// the squared distance of 32-bit inputs stays below 2^51, so it never saturates
module closest_points_between_segments_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_start_x/y/z, first_end_x/y/z, second_start_x/y/z, second_end_x/y/z
  input  logic [383:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // param_first, param_second, near_first_x/y/z, near_second_x/y/z,
  // dist_squared, case_code, 3 zero pad bits
  output logic [295:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  localparam int unsigned StDiv1  = 7;            // first step of the s divider
  localparam int unsigned StTp    = StDiv1 + 17;  // b*s product
  localparam int unsigned StDiv2  = StTp + 4;     // first step of the second divider
  localparam int unsigned StScl   = StDiv2 + 17;  // quotient routing and scaling
  localparam int unsigned NumSt   = StScl + 4;

  cpseg_pkg::item_t st [NumSt];
  logic [NumSt-1:0] v;
  logic [31:0]      lim;
  logic             en;

  // whole pipe advances unless the output beat is held
  assign en        = !v[NumSt-1] || m_tready;
  assign s_tready  = en;
  assign m_tvalid  = v[NumSt-1];
  assign cfg_ready = 1'b1;
  assign m_tdata   = {3'b000, st[NumSt-1].code, st[NumSt-1].dsq, st[NumSt-1].c2,
                      st[NumSt-1].c1, st[NumSt-1].t, st[NumSt-1].s};

  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= cpseg_pkg::LimInit;
    end else if (cfg_valid) begin
      lim <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NumSt-2:0], s_tvalid};
    end
  end

  // wide products split into halves: signed top 33 bits, unsigned low 34 bits
  function automatic logic [65:0] mul_hh(input logic [66:0] x, input logic [66:0] y);
    return 66'($signed(x[66:34])) * 66'($signed(y[66:34]));
  endfunction

  function automatic logic [67:0] mul_hl(input logic [66:0] x, input logic [66:0] y);
    return 68'($signed(x[66:34])) * 68'($signed({1'b0, y[33:0]}));
  endfunction

  function automatic logic [67:0] mul_ll(input logic [66:0] x, input logic [66:0] y);
    return 68'(x[33:0]) * 68'(y[33:0]);
  endfunction

  function automatic logic [133:0] mul_join(input logic [65:0] hh, input logic [67:0] hl,
                                            input logic [67:0] lh, input logic [67:0] ll);
    return (134'($signed(hh)) << 68) + ((134'($signed(hl)) + 134'($signed(lh))) << 34)
         + 134'(ll);
  endfunction

  // clamped quotient setup: zero, one, or start the bit loop
  function automatic cpseg_pkg::item_t div_setup(input cpseg_pkg::item_t x);
    cpseg_pkg::item_t y;
    y      = x;
    y.q    = '0;
    y.skip = 1'b1;
    y.rem  = '0;
    y.dv   = '0;
    if ($signed(x.dn) <= 0 || $signed(x.nm) <= 0) begin
      y.q = '0;
    end else if ($signed(x.nm) >= $signed(x.dn)) begin
      y.q = cpseg_pkg::OneQ16;
    end else begin
      y.skip = 1'b0;
      y.rem  = cpseg_pkg::DivW'(x.nm) << 16;
      y.dv   = cpseg_pkg::DivW'(x.dn);
    end
    return y;
  endfunction

  // one restoring step for quotient bit k
  function automatic cpseg_pkg::item_t div_step(input cpseg_pkg::item_t x,
                                                 input int unsigned k);
    cpseg_pkg::item_t    y;
    logic [cpseg_pkg::DivW-1:0] dk;
    y  = x;
    dk = x.dv << k;
    if (!x.skip && dk <= x.rem) begin
      y.rem  = x.rem - dk;
      y.q[k] = 1'b1;
    end
    return y;
  endfunction

  // stage 0: capture endpoints, form direction and offset vectors
  cpseg_pkg::item_t nx0;
  always_comb begin
    nx0 = st[0];
    for (int j = 0; j < 3; j++) begin
      nx0.p1[j] = s_tdata[32*j +: 32];
      nx0.p2[j] = s_tdata[192+32*j +: 32];
      nx0.d1[j] = 33'($signed(s_tdata[96+32*j +: 32])) - 33'($signed(s_tdata[32*j +: 32]));
      nx0.d2[j] = 33'($signed(s_tdata[288+32*j +: 32]))
                - 33'($signed(s_tdata[192+32*j +: 32]));
      nx0.r[j]  = 33'($signed(s_tdata[32*j +: 32])) - 33'($signed(s_tdata[192+32*j +: 32]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= nx0;
    end
  end

  for (genvar g = 1; g < NumSt; g++) begin : g_st
    cpseg_pkg::item_t nx;
    cpseg_pkg::item_t x;
    assign x = st[g-1];

    if (g == 1) begin : g_dotp
      // component products of the five dot products
      always_comb begin
        nx = x;
        for (int j = 0; j < 3; j++) begin
          nx.pr[j]    = 66'($signed(x.d1[j])) * 66'($signed(x.d1[j]));
          nx.pr[3+j]  = 66'($signed(x.d2[j])) * 66'($signed(x.d2[j]));
          nx.pr[6+j]  = 66'($signed(x.d1[j])) * 66'($signed(x.d2[j]));
          nx.pr[9+j]  = 66'($signed(x.d1[j])) * 66'($signed(x.r[j]));
          nx.pr[12+j] = 66'($signed(x.d2[j])) * 66'($signed(x.r[j]));
        end
      end
    end else if (g == 2) begin : g_dots
      always_comb begin
        nx = x;
        nx.a = 67'($signed(x.pr[0])) + 67'($signed(x.pr[1])) + 67'($signed(x.pr[2]));
        nx.e = 67'($signed(x.pr[3])) + 67'($signed(x.pr[4])) + 67'($signed(x.pr[5]));
        nx.b = 67'($signed(x.pr[6])) + 67'($signed(x.pr[7])) + 67'($signed(x.pr[8]));
        nx.c = 67'($signed(x.pr[9])) + 67'($signed(x.pr[10])) + 67'($signed(x.pr[11]));
        nx.f = 67'($signed(x.pr[12])) + 67'($signed(x.pr[13])) + 67'($signed(x.pr[14]));
      end
    end else if (g == 3) begin : g_cross
      // squared lengths are never negative, so an unsigned compare is exact
      // cross products start here as half-width partial products
      always_comb begin
        nx      = x;
        nx.adeg = x.a <= {35'd0, lim};
        nx.edeg = x.e <= {35'd0, lim};
        if (nx.adeg && nx.edeg) begin
          nx.code = cpseg_pkg::CASE_BOTH;
        end else if (nx.adeg) begin
          nx.code = cpseg_pkg::CASE_FIRST;
        end else if (nx.edeg) begin
          nx.code = cpseg_pkg::CASE_SECOND;
        end else begin
          nx.code = cpseg_pkg::CASE_GENERAL;
        end
        nx.phh[0] = mul_hh(x.a, x.e);
        nx.phl[0] = mul_hl(x.a, x.e);
        nx.plh[0] = mul_hl(x.e, x.a);
        nx.pll[0] = mul_ll(x.a, x.e);
        nx.phh[1] = mul_hh(x.b, x.b);
        nx.phl[1] = mul_hl(x.b, x.b);
        nx.plh[1] = mul_hl(x.b, x.b);
        nx.pll[1] = mul_ll(x.b, x.b);
        nx.phh[2] = mul_hh(x.b, x.f);
        nx.phl[2] = mul_hl(x.b, x.f);
        nx.plh[2] = mul_hl(x.f, x.b);
        nx.pll[2] = mul_ll(x.b, x.f);
        nx.phh[3] = mul_hh(x.c, x.e);
        nx.phl[3] = mul_hl(x.c, x.e);
        nx.plh[3] = mul_hl(x.e, x.c);
        nx.pll[3] = mul_ll(x.c, x.e);
      end
    end else if (g == 4) begin : g_join
      // partial products summed into the full cross terms
      always_comb begin
        nx     = x;
        nx.pae = mul_join(x.phh[0], x.phl[0], x.plh[0], x.pll[0]);
        nx.pbb = mul_join(x.phh[1], x.phl[1], x.plh[1], x.pll[1]);
        nx.pbf = mul_join(x.phh[2], x.phl[2], x.plh[2], x.pll[2]);
        nx.pce = mul_join(x.phh[3], x.phl[3], x.plh[3], x.pll[3]);
      end
    end else if (g == 5) begin : g_den
      always_comb begin
        nx    = x;
        nx.dn = 136'($signed(x.pae)) - 136'($signed(x.pbb));
        nx.nm = 136'($signed(x.pbf)) - 136'($signed(x.pce));
        if (x.code == cpseg_pkg::CASE_GENERAL && nx.dn == '0) begin
          nx.code = cpseg_pkg::CASE_PARALLEL;
        end
        if (x.code != cpseg_pkg::CASE_GENERAL) begin
          nx.dn = '0;
        end
      end
    end else if (g == StDiv1 - 1 || g == StDiv2 - 1) begin : g_setup
      always_comb begin
        nx = div_setup(x);
      end
    end else if (g >= StDiv1 && g < StDiv1 + 17) begin : g_div1
      always_comb begin
        nx = div_step(x, 32'(StDiv1 + 16 - g));
      end
    end else if (g == StTp) begin : g_tprod
      // b*s as two half-width products
      always_comb begin
        nx     = x;
        nx.s   = (x.code == cpseg_pkg::CASE_GENERAL) ? x.q : '0;
        nx.tpl = 51'(x.b[33:0]) * 51'(nx.s);
        nx.tph = 51'($signed(x.b[66:34])) * 51'($signed({1'b0, nx.s}));
      end
    end else if (g == StTp + 1) begin : g_tnum
      always_comb begin
        nx    = x;
        nx.tn = (86'($signed(x.tph)) <<< 34) + 86'(x.tpl) + (86'($signed(x.f)) <<< 16);
        nx.te = 86'(x.e) << 16;
      end
    end else if (g == StTp + 2) begin : g_sel
      // pick what the second divider works on and where its quotient goes
      always_comb begin
        nx = x;
        case (x.code)
          cpseg_pkg::CASE_BOTH: begin
            nx.nm = '0; nx.dn = '0; nx.tot = 1'b1; nx.s = '0; nx.t = '0;
          end
          cpseg_pkg::CASE_FIRST: begin
            nx.nm = 136'($signed(x.f)); nx.dn = 136'($signed(x.e));
            nx.tot = 1'b1; nx.s = '0;
          end
          cpseg_pkg::CASE_SECOND: begin
            nx.nm = -136'($signed(x.c)); nx.dn = 136'($signed(x.a));
            nx.tot = 1'b0; nx.t = '0;
          end
          default: begin
            if ($signed(x.tn) < 0) begin
              nx.t = '0; nx.tot = 1'b0;
              nx.nm = -136'($signed(x.c)); nx.dn = 136'($signed(x.a));
            end else if ($signed(x.tn) > $signed(x.te)) begin
              nx.t = cpseg_pkg::OneQ16; nx.tot = 1'b0;
              nx.nm = 136'($signed(x.b)) - 136'($signed(x.c));
              nx.dn = 136'($signed(x.a));
            end else begin
              nx.tot = 1'b1;
              nx.nm = 136'($signed(x.tn)); nx.dn = 136'($signed(x.te));
            end
          end
        endcase
      end
    end else if (g >= StDiv2 && g < StDiv2 + 17) begin : g_div2
      always_comb begin
        nx = div_step(x, 32'(StDiv2 + 16 - g));
      end
    end else if (g == StScl) begin : g_scale
      always_comb begin
        nx = x;
        if (x.tot) begin
          nx.t = x.q;
        end else begin
          nx.s = x.q;
        end
        for (int j = 0; j < 3; j++) begin
          nx.ds1[j] = 51'($signed(x.d1[j])) * 51'($signed({1'b0, nx.s}));
          nx.ds2[j] = 51'($signed(x.d2[j])) * 51'($signed({1'b0, nx.t}));
        end
      end
    end else if (g == StScl + 1) begin : g_point
      // round to nearest, ties up, then offset from the start point
      logic signed [51:0] r1 [3];
      logic signed [51:0] r2 [3];
      always_comb begin
        nx = x;
        for (int j = 0; j < 3; j++) begin
          r1[j]     = 52'($signed(x.ds1[j])) + 52'sd32768;
          r2[j]     = 52'($signed(x.ds2[j])) + 52'sd32768;
          nx.c1[j]  = x.p1[j] + r1[j][47:16];
          nx.c2[j]  = x.p2[j] + r2[j][47:16];
          nx.df[j]  = 33'($signed(nx.c1[j])) - 33'($signed(nx.c2[j]));
        end
      end
    end else if (g == StScl + 2) begin : g_sq
      always_comb begin
        nx = x;
        for (int j = 0; j < 3; j++) begin
          nx.sq[j] = 66'($signed(x.df[j])) * 66'($signed(x.df[j]));
        end
      end
    end else begin : g_dist
      logic [66:0] sum;
      always_comb begin
        nx     = x;
        sum    = 67'(x.sq[0]) + 67'(x.sq[1]) + 67'(x.sq[2]);
        nx.dsq = 64'(sum[66:16]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[g] <= nx;
      end
    end
  end

endmodule
